FILE: src/rotary_encoder_button_decoder_assert.svh
// Assertion macros for the encoder decoder; expect clk and arst_n in scope.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_ASSERT_SVH

// Same-cycle implication.
`define REBD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define REBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rebd_pkg.sv
package rebd_pkg;

	localparam int CountWidthDef = 32;
	localparam int TimeW         = 32;
	localparam int DeltaW        = 32;
	localparam int EvW           = 3;
	localparam int InFieldsW     = TimeW + 3;
	localparam int OutFieldsW    = EvW + DeltaW;
	localparam int InDataW       = ((InFieldsW + 7) / 8) * 8;
	localparam int OutDataW      = ((OutFieldsW + 7) / 8) * 8;
	localparam int CfgIdxW       = 3;
	localparam int CfgDataW      = 16;

	localparam logic [7:0]  DebounceDef   = 8'd20;
	localparam logic [7:0]  FastStepDef   = 8'd30;
	localparam logic [15:0] ShortClickDef = 16'd50;
	localparam logic [15:0] LongPressDef  = 16'd500;
	localparam logic [15:0] DragHoldDef   = 16'd500;

	typedef enum logic [CfgIdxW-1:0] {
		REG_REVERSE     = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_FAST_STEP   = 3'd2,
		REG_SHORT_CLICK = 3'd3,
		REG_LONG_PRESS  = 3'd4,
		REG_DRAG_HOLD   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CK_IDLE       = 3'd0,
		CK_PRESSED    = 3'd1,
		CK_CLICKED    = 3'd2,
		CK_LONG       = 3'd3,
		CK_UNRELEASED = 3'd4,
		CK_DRAG       = 3'd5
	} click_t;

	typedef enum logic [EvW-1:0] {
		EV_NONE      = 3'd0,
		EV_INC       = 3'd1,
		EV_DEC       = 3'd2,
		EV_INC_DRAG  = 3'd3,
		EV_DEC_DRAG  = 3'd4,
		EV_CLICK     = 3'd5,
		EV_LONG      = 3'd6
	} evt_code_t;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_READ = 1'b1;

endpackage

FILE: src/rotary_encoder_button_decoder.sv
// Rotary encoder with push button, fed by sampled pin levels.
// Input stream (s_*): one beat per sample or read. tuser is the mode
// (0 sample tick, 1 read); tdata holds now_ms, pin_a, pin_b, button_level.
// A tick updates debounce, rotation and click state and gives no output.
// Output stream (m_*): one beat per read, tdata holds event_res and the
// signed count change since the previous read.
// Config port: cfg_we writes cfg_data into register cfg_idx at the clock
// edge; indexes above five are ignored. Write only while idle.
// A beat accepted sits in the input register until it is applied to the
// state registers; as a read is applied, its result lands in the output register.
// Throughput: one beat per cycle unless a read stalls, set by the single
// combinational pass from the input register to the state/output registers.
// Stall: a held output beat keeps a read in the input register, and with it
// every beat behind it; ticks pass freely while no read waits there.
// s_tready depends combinationally on m_tready through the input register.
// Reset: config registers go to their defaults, the button reads released,
// both encoder lines low, counts zero, no beat held.
module rotary_encoder_button_decoder #(
	parameter int COUNT_WIDTH = rebd_pkg::CountWidthDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rebd_pkg::InDataW-1:0] s_tdata,   // now_ms, pin_a, pin_b, button_level
	input  logic                         s_tuser,   // mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rebd_pkg::OutDataW-1:0] m_tdata,  // event_res, count_delta
	input  logic                         cfg_we,
	input  logic [rebd_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [rebd_pkg::CfgDataW-1:0] cfg_data
);
	import rebd_pkg::*;

	// config
	logic        reverse_q;
	logic [7:0]  debounce_q;
	logic [7:0]  fast_step_q;
	logic [15:0] short_click_q;
	logic [15:0] long_press_q;
	logic [15:0] drag_hold_q;

	// input stage
	logic                 valid_s1;
	logic                 mode_s1;
	logic [InFieldsW-1:0] fields_s1;
	logic                 adv_s1;

	// state
	logic btn_raw_q, btn_set_q, a_raw_q, a_set_q, b_raw_q, b_set_q;
	logic hp_seen_q, turn_cw_q;
	logic [TimeW-1:0] deb_start_q, press_start_q, hp_start_q, last_step_q;
	click_t click_q;
	logic [COUNT_WIDTH-1:0] step_total_q, reported_q;

	logic m_tvalid_q;
	logic [OutFieldsW-1:0] m_fields_q;

	// next state from a tick
	logic btn_raw_n, btn_set_n, a_raw_n, a_set_n, b_raw_n, b_set_n;
	logic hp_seen_n, turn_cw_n;
	logic [TimeW-1:0] deb_start_n, press_start_n, hp_start_n, last_step_n;
	click_t click_n;
	logic [COUNT_WIDTH-1:0] step_total_n;

	logic [TimeW-1:0] t_s1;
	logic pin_a_s1, pin_b_s1, btn_s1;
	logic [TimeW-1:0] held, stable, since_step, since_hp;
	logic [COUNT_WIDTH-1:0] step_add;
	logic skip;

	// read result
	logic signed [COUNT_WIDTH-1:0] diff;
	logic [DeltaW-1:0] delta32;
	evt_code_t ev;
	logic rd_adv, rd_wait, click_pend;

	assign t_s1     = fields_s1[TimeW-1:0];
	assign pin_a_s1 = fields_s1[TimeW];
	assign pin_b_s1 = fields_s1[TimeW+1];
	assign btn_s1   = fields_s1[TimeW+2];

	assign adv_s1   = valid_s1 && (mode_s1 == MODE_TICK || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OutDataW'(m_fields_q);

	assign rd_adv     = adv_s1 && mode_s1 == MODE_READ;
	assign rd_wait    = valid_s1 && mode_s1 == MODE_READ && !adv_s1;
	assign click_pend = click_q == CK_CLICKED || click_q == CK_LONG;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q     <= 1'b0;
			debounce_q    <= DebounceDef;
			fast_step_q   <= FastStepDef;
			short_click_q <= ShortClickDef;
			long_press_q  <= LongPressDef;
			drag_hold_q   <= DragHoldDef;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REVERSE:     reverse_q     <= cfg_data[0];
				REG_DEBOUNCE:    debounce_q    <= cfg_data[7:0];
				REG_FAST_STEP:   fast_step_q   <= cfg_data[7:0];
				REG_SHORT_CLICK: short_click_q <= cfg_data;
				REG_LONG_PRESS:  long_press_q  <= cfg_data;
				REG_DRAG_HOLD:   drag_hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1   <= s_tuser;
			fields_s1 <= s_tdata[InFieldsW-1:0];
		end
	end

	always_comb begin
		btn_raw_n     = btn_raw_q;
		btn_set_n     = btn_set_q;
		a_raw_n       = a_raw_q;
		a_set_n       = a_set_q;
		b_raw_n       = b_raw_q;
		b_set_n       = b_set_q;
		hp_seen_n     = hp_seen_q;
		turn_cw_n     = turn_cw_q;
		deb_start_n   = deb_start_q;
		press_start_n = press_start_q;
		hp_start_n    = hp_start_q;
		last_step_n   = last_step_q;
		click_n       = click_q;
		step_total_n  = step_total_q;
		skip          = 1'b0;

		held       = t_s1 - press_start_q;
		stable     = t_s1 - deb_start_q;
		since_step = t_s1 - last_step_q;
		since_hp   = t_s1 - hp_start_q;
		step_add   = (since_step < TimeW'(fast_step_q)) ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1);

		if (btn_raw_q != btn_s1) begin
			btn_raw_n   = btn_s1;
			deb_start_n = t_s1;
			skip        = 1'b1;
		end else if (btn_set_q != btn_s1 && stable > TimeW'(debounce_q)) begin
			btn_set_n = btn_s1;
		end
		if (a_raw_q != pin_a_s1) begin
			a_raw_n = pin_a_s1;
			skip    = 1'b1;
		end else begin
			a_set_n = pin_a_s1;
		end
		if (b_raw_q != pin_b_s1) begin
			b_raw_n = pin_b_s1;
			skip    = 1'b1;
		end else begin
			b_set_n = pin_b_s1;
		end

		if (!skip) begin
			if (a_set_n && b_set_n) begin
				if (hp_seen_q) begin
					hp_seen_n   = 1'b0;
					last_step_n = t_s1;
					if (turn_cw_q != reverse_q)
						step_total_n = step_total_q + step_add;
					else
						step_total_n = step_total_q - step_add;
				end
			end else if (!a_set_n && !b_set_n) begin
				if (!hp_seen_q) begin
					hp_start_n = t_s1;
					hp_seen_n  = 1'b1;
					if (!btn_set_n)
						click_n = CK_DRAG;
				end else if (since_hp > TimeW'(drag_hold_q)) begin
					if (!btn_set_n && click_n == CK_DRAG)
						click_n = CK_PRESSED;
				end
			end else if (!hp_seen_q) begin
				turn_cw_n = a_set_n;
			end

			if (click_n == CK_DRAG) begin
				if (btn_set_n)
					click_n = CK_IDLE;
			end else begin
				if (click_n == CK_IDLE && !btn_set_n) begin
					click_n       = CK_PRESSED;
					press_start_n = t_s1;
				end else if (click_n == CK_PRESSED) begin
					if (!btn_set_n && held > TimeW'(long_press_q))
						click_n = CK_LONG;
					else if (btn_set_n && held > TimeW'(short_click_q))
						click_n = CK_CLICKED;
				end
				if (click_n == CK_UNRELEASED && btn_set_n)
					click_n = CK_IDLE;
			end
		end
	end

	always_comb begin
		diff    = step_total_q - reported_q;
		delta32 = DeltaW'(diff);
		if (click_q == CK_CLICKED)
			ev = EV_CLICK;
		else if (click_q == CK_LONG)
			ev = EV_LONG;
		else if (diff[COUNT_WIDTH-1])
			ev = (click_q == CK_DRAG) ? EV_DEC_DRAG : EV_DEC;
		else if (diff != '0)
			ev = (click_q == CK_DRAG) ? EV_INC_DRAG : EV_INC;
		else
			ev = EV_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_raw_q     <= 1'b1;
			btn_set_q     <= 1'b1;
			a_raw_q       <= 1'b0;
			a_set_q       <= 1'b0;
			b_raw_q       <= 1'b0;
			b_set_q       <= 1'b0;
			hp_seen_q     <= 1'b0;
			turn_cw_q     <= 1'b0;
			deb_start_q   <= '0;
			press_start_q <= '0;
			hp_start_q    <= '0;
			last_step_q   <= '0;
			click_q       <= CK_IDLE;
			step_total_q  <= '0;
			reported_q    <= '0;
		end else if (adv_s1) begin
			if (mode_s1 == MODE_READ) begin
				reported_q <= step_total_q;
				if (click_pend)
					click_q <= CK_UNRELEASED;
			end else begin
				btn_raw_q     <= btn_raw_n;
				btn_set_q     <= btn_set_n;
				a_raw_q       <= a_raw_n;
				a_set_q       <= a_set_n;
				b_raw_q       <= b_raw_n;
				b_set_q       <= b_set_n;
				hp_seen_q     <= hp_seen_n;
				turn_cw_q     <= turn_cw_n;
				deb_start_q   <= deb_start_n;
				press_start_q <= press_start_n;
				hp_start_q    <= hp_start_n;
				last_step_q   <= last_step_n;
				click_q       <= click_n;
				step_total_q  <= step_total_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rd_adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_adv)
			m_fields_q <= {delta32, ev};
	end

`include "rotary_encoder_button_decoder_assert.svh"

	`REBD_ASSERT_NEXT(a_read_fills_out, rd_adv, m_tvalid, "read beat lost")
	`REBD_ASSERT_NEXT(a_read_held, rd_wait, valid_s1, "stalled read dropped")
	`REBD_ASSERT_NEXT(a_click_consumed, rd_adv && click_pend, click_q == CK_UNRELEASED, "click not consumed")
	`REBD_ASSERT_IMPL(a_ready_when_empty, !valid_s1, s_tready, "input stage empty but not ready")

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rebd_pkg::*;

	typedef struct packed {
		evt_code_t   ev;
		logic [31:0] delta;
	} read_res_t;

	typedef struct {
		logic        mode;
		logic [31:0] stamp;
		bit          a;
		bit          b;
		bit          btn;
		bit          pinned;   // expected result typed in below
		evt_code_t   ev;
		logic [31:0] delta;
	} stim_row_t;

	localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata  = '0;
	logic                s_tuser  = MODE_TICK;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we   = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx  = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// sideband that travels with the beat on the input
	bit          beat_pinned = 1'b0;
	evt_code_t   beat_ev     = EV_NONE;
	logic [31:0] beat_delta  = '0;

	rotary_encoder_button_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// decoder shadow state
	bit          cfg_reverse;
	logic [7:0]  cfg_debounce, cfg_fast;
	logic [15:0] cfg_short, cfg_long, cfg_drag;
	bit          btn_raw, btn_stable, a_raw, a_steady, b_raw, b_steady;
	bit          half_seen, turn_cw;
	logic [31:0] db_start, press_t0, half_t0, last_step, steps, reported;
	click_t      click;

	read_res_t   pending_reads[$];
	int          fails;
	int          sent;
	int          burst_left;

	task automatic enc_reset();
		cfg_reverse = 1'b0;
		cfg_debounce = DebounceDef;
		cfg_fast = FastStepDef;
		cfg_short = ShortClickDef;
		cfg_long = LongPressDef;
		cfg_drag = DragHoldDef;
		btn_raw = 1'b1;
		btn_stable = 1'b1;
		a_raw = 1'b0;
		a_steady = 1'b0;
		b_raw = 1'b0;
		b_steady = 1'b0;
		half_seen = 1'b0;
		turn_cw = 1'b0;
		db_start = '0;
		press_t0 = '0;
		half_t0 = '0;
		last_step = '0;
		steps = '0;
		reported = '0;
		click = CK_IDLE;
	endtask

	task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		case (idx)
			REG_REVERSE:     cfg_reverse = val[0];
			REG_DEBOUNCE:    cfg_debounce = val[7:0];
			REG_FAST_STEP:   cfg_fast = val[7:0];
			REG_SHORT_CLICK: cfg_short = val;
			REG_LONG_PRESS:  cfg_long = val;
			REG_DRAG_HOLD:   cfg_drag = val;
			default: ;
		endcase
	endtask

	task automatic enc_tick(logic [31:0] t, bit a, bit b, bit btn);
		logic [31:0] held, stable, add;
		bit skip;
		held = t - press_t0;
		stable = t - db_start;
		skip = 1'b0;
		if (btn_raw != btn) begin
			btn_raw = btn;
			db_start = t;
			skip = 1'b1;
		end else if (btn_stable != btn && stable > cfg_debounce) begin
			btn_stable = btn;
		end
		if (a_raw != a) begin
			a_raw = a;
			skip = 1'b1;
		end else
			a_steady = a;
		if (b_raw != b) begin
			b_raw = b;
			skip = 1'b1;
		end else
			b_steady = b;
		if (skip)
			return;

		if (a_steady && b_steady) begin
			if (half_seen) begin
				add = ((t - last_step) < cfg_fast) ? 32'd2 : 32'd1;
				half_seen = 1'b0;
				last_step = t;
				if (turn_cw != cfg_reverse)
					steps = steps + add;
				else
					steps = steps - add;
			end
		end else if (!a_steady && !b_steady) begin
			if (!half_seen) begin
				half_t0 = t;
				half_seen = 1'b1;
				if (!btn_stable)
					click = CK_DRAG;
			end else if ((t - half_t0) > cfg_drag) begin
				if (!btn_stable && click == CK_DRAG)
					click = CK_PRESSED;
			end
		end else if (!half_seen) begin
			turn_cw = a_steady;
		end

		if (click == CK_DRAG) begin
			if (btn_stable)
				click = CK_IDLE;
		end else begin
			if (click == CK_IDLE && !btn_stable) begin
				click = CK_PRESSED;
				press_t0 = t;
			end else if (click == CK_PRESSED) begin
				if (!btn_stable && held > cfg_long)
					click = CK_LONG;
				else if (btn_stable && held > cfg_short)
					click = CK_CLICKED;
			end
			if (click == CK_UNRELEASED && btn_stable)
				click = CK_IDLE;
		end
	endtask

	function automatic read_res_t enc_read();
		read_res_t r;
		r.delta = steps - reported;
		reported = steps;
		if (click == CK_CLICKED) begin
			click = CK_UNRELEASED;
			r.ev = EV_CLICK;
		end else if (click == CK_LONG) begin
			click = CK_UNRELEASED;
			r.ev = EV_LONG;
		end else if (r.delta[31]) begin
			r.ev = (click == CK_DRAG) ? EV_DEC_DRAG : EV_DEC;
		end else if (r.delta != 0) begin
			r.ev = (click == CK_DRAG) ? EV_INC_DRAG : EV_INC;
		end else begin
			r.ev = EV_NONE;
		end
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		fails++;
		$display("%0t: %s expected %0d got %0d", $time, field,
			$signed(want), $signed(got));
	endtask

	// one process checks results first, then books the incoming beat
	always @(posedge clk) begin : scoreboard
		read_res_t want, fresh;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_reads.size() == 0) begin
					fails++;
					$display("%0t: unexpected beat, got event %0d delta %0d", $time,
						m_tdata[2:0], $signed(m_tdata[34:3]));
				end else begin
					want = pending_reads.pop_front();
					if (m_tdata[2:0] !== want.ev)
						note_mismatch("event_res", 32'(want.ev), 32'(m_tdata[2:0]));
					if (m_tdata[34:3] !== want.delta)
						note_mismatch("count_delta", want.delta, m_tdata[34:3]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_READ) begin
					fresh = enc_read();
					if (beat_pinned) begin
						fresh.ev = beat_ev;
						fresh.delta = beat_delta;
					end
					pending_reads.push_back(fresh);
				end else begin
					enc_tick(s_tdata[31:0], s_tdata[32], s_tdata[33], s_tdata[34]);
				end
			end
		end
	end

	// receiver stall pattern
	int rx_mode, rx_left;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else
			rx_left = rx_left - 1;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_left % 5 == 0);
			default: m_tready <= (rx_left % 17 > 12);
		endcase
	end

	function automatic stim_row_t tick_row(logic [31:0] t, bit [1:0] ab, bit btn);
		stim_row_t r;
		r = '{MODE_TICK, t, ab[1], ab[0], btn, 1'b0, EV_NONE, 32'd0};
		return r;
	endfunction

	function automatic stim_row_t read_row(logic [31:0] t, bit [1:0] ab, bit btn,
			bit pinned, evt_code_t ev, logic [31:0] delta);
		stim_row_t r;
		r = '{MODE_READ, t, ab[1], ab[0], btn, pinned, ev, delta};
		return r;
	endfunction

	task automatic send_beat(stim_row_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= r.mode;
		s_tdata <= InDataW'({r.btn, r.b, r.a, r.stamp});
		beat_pinned <= r.pinned;
		beat_ev <= r.ev;
		beat_delta <= r.delta;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] rev, logic [15:0] deb, logic [15:0] fast,
			logic [15:0] shrt, logic [15:0] lng, logic [15:0] drag);
		write_reg(REG_REVERSE, rev);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_FAST_STEP, fast);
		write_reg(REG_SHORT_CLICK, shrt);
		write_reg(REG_LONG_PRESS, lng);
		write_reg(REG_DRAG_HOLD, drag);
	endtask

	// random-stream levels and clock
	logic [31:0] clock_ms;
	bit          cur_a, cur_b, cur_btn;

	task automatic hold_levels(int n, int max_dt);
		repeat (n) begin
			clock_ms = clock_ms + $urandom_range(0, max_dt);
			send_beat(tick_row(clock_ms, {cur_a, cur_b}, cur_btn));
		end
	endtask

	task automatic turn_detent();
		int speeds[3] = '{2, 10, 40};
		int stop_at, max_dt;
		bit ccw;
		ccw = $urandom_range(0, 1);
		stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
		max_dt = speeds[$urandom_range(0, 2)];
		for (int i = 0; i < stop_at; i++) begin
			case (i)
				0: {cur_a, cur_b} = ccw ? 2'b01 : 2'b10;
				1: {cur_a, cur_b} = 2'b00;
				2: {cur_a, cur_b} = ccw ? 2'b10 : 2'b01;
				default: {cur_a, cur_b} = 2'b11;
			endcase
			// a single sample makes a bounce
			hold_levels(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4), max_dt);
		end
	endtask

	task automatic toggle_button();
		int speeds[4] = '{3, 12, 40, 150};
		cur_btn = !cur_btn;
		hold_levels($urandom_range(2, 6), speeds[$urandom_range(0, 3)]);
	endtask

	task automatic random_segment();
		int pick;
		bit [2:0] lv;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			turn_detent();
		else if (pick < 58)
			toggle_button();
		else if (pick < 83) begin
			lv = 3'($urandom);
			send_beat(read_row($urandom, lv[2:1], lv[0], 1'b0, EV_NONE, 32'd0));
		end else if (pick < 95)
			hold_levels($urandom_range(1, 4), 250);
		else begin
			clock_ms = $urandom;
			{cur_a, cur_b, cur_btn} = 3'($urandom);
			send_beat(tick_row(clock_ms, {cur_a, cur_b}, cur_btn));
		end
	endtask

	stim_row_t opening_rows[$];

	initial begin
		logic [31:0] t0;
		enc_reset();
		fails = 0;
		sent = 0;
		burst_left = 0;
		rx_mode = 0;
		rx_left = 0;

		// clockwise detent across the time wrap, then a fast counter-clockwise one,
		// then a read, a click and two more reads
		t0 = 32'hFFFF_FFF6;
		opening_rows.push_back(read_row(32'd0, 2'b00, 1'b1, 1'b1, EV_NONE, 32'd0));
		opening_rows.push_back(tick_row(t0 + 0, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(t0 + 1, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(t0 + 2, 2'b10, 1'b1));
		opening_rows.push_back(tick_row(t0 + 3, 2'b10, 1'b1));
		opening_rows.push_back(tick_row(t0 + 4, 2'b00, 1'b1));
		opening_rows.push_back(tick_row(t0 + 5, 2'b00, 1'b1));
		opening_rows.push_back(tick_row(t0 + 6, 2'b01, 1'b1));
		opening_rows.push_back(tick_row(t0 + 7, 2'b01, 1'b1));
		opening_rows.push_back(tick_row(t0 + 8, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(t0 + 9, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(t0 + 10, 2'b01, 1'b1));
		opening_rows.push_back(tick_row(t0 + 11, 2'b01, 1'b1));
		opening_rows.push_back(tick_row(t0 + 12, 2'b00, 1'b1));
		opening_rows.push_back(tick_row(t0 + 13, 2'b00, 1'b1));
		opening_rows.push_back(tick_row(t0 + 14, 2'b10, 1'b1));
		opening_rows.push_back(tick_row(t0 + 15, 2'b10, 1'b1));
		opening_rows.push_back(tick_row(t0 + 16, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(t0 + 17, 2'b11, 1'b1));
		opening_rows.push_back(read_row(32'd0, 2'b00, 1'b0, 1'b0, EV_NONE, 32'd0));
		opening_rows.push_back(tick_row(32'd20, 2'b11, 1'b0));
		opening_rows.push_back(tick_row(32'd45, 2'b11, 1'b0));
		opening_rows.push_back(tick_row(32'd120, 2'b11, 1'b1));
		opening_rows.push_back(tick_row(32'd145, 2'b11, 1'b1));
		opening_rows.push_back(read_row(32'd0, 2'b00, 1'b0, 1'b0, EV_NONE, 32'd0));
		// click already taken, nothing turned: fields of a read are ignored
		opening_rows.push_back(read_row(32'hFFFF_FFFF, 2'b11, 1'b1, 1'b1, EV_NONE, 32'd0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_beat(opening_rows[i]);

		clock_ms = 32'd1000;
		{cur_a, cur_b, cur_btn} = 3'b111;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0)
				drain();
			case (phase)
				0: ;
				1: set_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				2: set_regs(16'd0, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: begin
					// upper bits are dropped; spare indexes write nothing
					set_regs(16'hFFFE, 16'hAB05, 16'h1240, 16'd100, 16'd300, 16'd200);
					write_reg(REG_SPARE_6, 16'hFFFF);
					write_reg(REG_SPARE_7, 16'h0001);
				end
				default: set_regs(16'($urandom_range(0, 1)), 16'($urandom_range(0, 40)),
					16'($urandom_range(0, 60)), 16'($urandom_range(0, 150)),
					16'($urandom_range(100, 700)), 16'($urandom_range(50, 700)));
			endcase
			if (phase == 2 || phase == 4)
				clock_ms = 32'hFFFF_F000 + $urandom_range(0, 255);
			while (sent < opening_rows.size() + 300 * (phase + 1))
				random_segment();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
